// ===== src/additive_oscillator_bank_unit_assert.svh =====
// Assertion macros used by the oscillator bank controller.
`ifndef ADDITIVE_OSCILLATOR_BANK_UNIT_ASSERT_SVH
`define ADDITIVE_OSCILLATOR_BANK_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define AOB_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define AOB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define AOB_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define AOB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== src/aob_pkg.sv =====
package aob_pkg;

    localparam int CHANNELS     = 256;
    localparam int SINE_ENTRIES = 1024;

    localparam int CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SE_BITS  = $clog2(SINE_ENTRIES);
    localparam int QUARTER  = SINE_ENTRIES / 4;
    localparam int QB       = SE_BITS - 2;

    localparam int PHASE_W  = 32;
    localparam int VOL_W    = 8;
    localparam int SMP_W    = 16;
    localparam int SIN_W    = 16;
    localparam int GAIN_W   = 24;
    localparam int ROWS_W   = 9;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = VOL_W + SIN_W + 1;
    localparam int ACC_W    = VOL_W + SIN_W + CH_BITS + 1;
    localparam int GAIN_SHIFT = 31;
    localparam int SCL_W    = ACC_W + GAIN_W - GAIN_SHIFT;

    // pipeline stages behind the channel issue: read, index, lookup, multiply
    localparam int DRAIN_CYCLES = 4;
    localparam int WAIT_W       = 3;

    // floor(t/3) for t <= 765 as (t*683) >> 11
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_INC  = 2'd0,
        CFG_INC_STEP = 2'd1,
        CFG_ROWS     = 2'd2,
        CFG_GAIN     = 2'd3
    } t_cfg_reg;

    localparam logic [PHASE_W-1:0] TOP_INC_RST  = 32'd1947836737;
    localparam logic [PHASE_W-1:0] INC_STEP_RST = 32'hFF97_829D;
    localparam logic [ROWS_W-1:0]  ROWS_RST     = 9'd256;
    localparam logic [GAIN_W-1:0]  GAIN_RST     = 24'd30118;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    typedef struct packed {
        logic start;       // clear accumulator and channel count, load top increment
        logic issue;       // send the next channel down the pipe
        logic phase_done;  // every phase entry now holds a written value
        logic mag;         // take magnitude of the sum
        logic mul;         // apply output gain
        logic load_out;    // saturate into the output register
        logic pix_write;   // store a pixel volume
    } t_ctrl_cmd;

    typedef struct packed {
        logic last_ch;
    } t_dp_status;

    typedef logic [SIN_W-2:0] t_qtab [QUARTER];

    // Quarter-wave sine magnitude, unsigned Q0.15, from a truncated Taylor series in Q30
    function automatic logic [SIN_W-2:0] sine_mag(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned s;
        longint unsigned v;
        x    = (r * HALF_PI_Q30) / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        pos  = x;
        neg  = 0;
        term = ((term * x2) >> 30) / 6;   neg += term;
        term = ((term * x2) >> 30) / 20;  pos += term;
        term = ((term * x2) >> 30) / 42;  neg += term;
        term = ((term * x2) >> 30) / 72;  pos += term;
        term = ((term * x2) >> 30) / 110; neg += term;
        term = ((term * x2) >> 30) / 156; pos += term;
        term = ((term * x2) >> 30) / 210; neg += term;
        s = (pos > neg) ? (pos - neg) : 64'd0;
        v = (s * 32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return v[SIN_W-2:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab tab;
        for (int i = 0; i < QUARTER; i++) begin
            tab[i] = sine_mag(longint'(i));
        end
        return tab;
    endfunction

    localparam t_qtab SINE_QTAB = build_qtab();
    localparam logic [SIN_W-2:0] SINE_PEAK = sine_mag(longint'(QUARTER));

endpackage

// ===== src/additive_oscillator_bank_unit.sv =====
// Additive sine oscillator bank. A pixel word (mode 0) stores floor((B+G+R)/3) as
// the volume of channel row_index and gives no result. A tick word
// (mode 1) sweeps all channels through one shared pipeline (phase/volume RAM read,
// quarter-wave sine lookup, volume multiply, accumulate), one channel per cycle,
// advancing every phase, then applies the gain and saturates. One result word
// per tick; the result register lets the next item in while a word still waits.
// Configuration is taken through the write port at any time the block is idle.
module additive_oscillator_bank_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_mode,
    input  logic [7:0]                         i_row_index,
    input  logic [7:0]                         i_blue_level,
    input  logic [7:0]                         i_green_level,
    input  logic [7:0]                         i_red_level,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [aob_pkg::SMP_W-1:0]   o_audio_sample,
    input  logic                               i_cfg_we,
    input  logic [aob_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [aob_pkg::CFG_W-1:0]          i_cfg_data
);

    aob_pkg::t_ctrl_cmd  w_cmd;
    aob_pkg::t_dp_status w_status;

    aob_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    aob_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_row_index    (i_row_index),
        .i_blue_level   (i_blue_level),
        .i_green_level  (i_green_level),
        .i_red_level    (i_red_level),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_audio_sample (o_audio_sample)
    );

endmodule

// ===== src/aob_ram.sv =====
module aob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/aob_ctrl.sv =====
`include "additive_oscillator_bank_unit_assert.svh"

module aob_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_mode,
    output logic                  o_stall,
    output logic                  o_valid,
    input  logic                  i_stall,
    input  aob_pkg::t_dp_status   i_status,
    output aob_pkg::t_ctrl_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RUN   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_MAG   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]                   r_state, n_state;
    logic [aob_pkg::WAIT_W-1:0]   r_wait, n_wait;
    logic                         r_out_valid, n_out_valid;
    logic                         w_accept;
    logic                         w_out_free;

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_mode) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RUN;
                    end else begin
                        o_cmd.pix_write = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_ch) begin
                    n_wait  = '0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_wait = r_wait + 1'b1;
                if (r_wait == aob_pkg::WAIT_W'(aob_pkg::DRAIN_CYCLES - 1)) begin
                    n_state = S_MAG;
                end
            end
            S_MAG: begin
                o_cmd.mag        = 1'b1;
                o_cmd.phase_done = 1'b1;
                n_state          = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    `AOB_ASSERT_CLK(a_tick_starts_run, i_clk, i_rst_n, (i_valid && !o_stall && i_mode) |=> (r_state == S_RUN), "tick word did not start a channel sweep")
    `AOB_ASSERT_CLK(a_result_from_final, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_OUT), "result word appeared outside the final step")
    `AOB_ASSERT_NEVER(a_drain_bound, i_clk, i_rst_n, (r_state == S_DRAIN) && (r_wait >= aob_pkg::WAIT_W'(aob_pkg::DRAIN_CYCLES)), "drain count ran past the pipeline depth")
    `AOB_ASSERT_CLK(a_held_result_waits, i_clk, i_rst_n, (r_state == S_OUT && r_out_valid && i_stall) |=> (r_state == S_OUT), "new result overran a stalled word")

endmodule

// ===== src/aob_dp.sv =====
module aob_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  aob_pkg::t_ctrl_cmd                 i_cmd,
    output aob_pkg::t_dp_status                o_status,
    input  logic [7:0]                         i_row_index,
    input  logic [7:0]                         i_blue_level,
    input  logic [7:0]                         i_green_level,
    input  logic [7:0]                         i_red_level,
    input  logic                               i_cfg_we,
    input  logic [aob_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [aob_pkg::CFG_W-1:0]          i_cfg_data,
    output logic signed [aob_pkg::SMP_W-1:0]   o_audio_sample
);

    localparam int CH_BITS = aob_pkg::CH_BITS;
    localparam int PW      = aob_pkg::PHASE_W;
    localparam int QB      = aob_pkg::QB;
    localparam int SE_BITS = aob_pkg::SE_BITS;

    // configuration
    logic [PW-1:0]                    r_top_inc;
    logic [PW-1:0]                    r_inc_step;
    logic [aob_pkg::ROWS_W-1:0]       r_rows;
    logic [aob_pkg::GAIN_W-1:0]       r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_inc  <= aob_pkg::TOP_INC_RST;
            r_inc_step <= aob_pkg::INC_STEP_RST;
            r_rows     <= aob_pkg::ROWS_RST;
            r_gain     <= aob_pkg::GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (aob_pkg::t_cfg_reg'(i_cfg_index))
                aob_pkg::CFG_TOP_INC:  r_top_inc  <= i_cfg_data;
                aob_pkg::CFG_INC_STEP: r_inc_step <= i_cfg_data;
                aob_pkg::CFG_ROWS:     r_rows     <= i_cfg_data[aob_pkg::ROWS_W-1:0];
                aob_pkg::CFG_GAIN:     r_gain     <= i_cfg_data[aob_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pixel volume: gray = floor(sum/3)
    logic [9:0]                w_total;
    logic [19:0]               w_gray_prod;
    logic [aob_pkg::VOL_W-1:0] w_gray;
    logic [15:0]               w_row_ext;
    logic                      w_row_ok;
    logic [CH_BITS-1:0]        w_pix_addr;
    logic                      w_pix_we;

    assign w_total     = {2'b00, i_blue_level} + {2'b00, i_green_level}
                       + {2'b00, i_red_level};
    assign w_gray_prod = 20'(w_total) * 20'(aob_pkg::DIV3_MUL);
    assign w_gray      = w_gray_prod[aob_pkg::DIV3_SHIFT +: aob_pkg::VOL_W];
    assign w_row_ext   = {8'd0, i_row_index};
    assign w_row_ok    = (w_row_ext < 16'(aob_pkg::CHANNELS));
    assign w_pix_addr  = w_row_ext[CH_BITS-1:0];
    assign w_pix_we    = i_cmd.pix_write && w_row_ok;

    // volumes never written read as zero
    logic [aob_pkg::CHANNELS-1:0] r_vol_valid;
    logic                         r_phase_done;

    // channel issue
    logic [CH_BITS-1:0]  r_ch;
    logic [PW-1:0]       r_inc;
    logic                w_active;

    assign w_active        = (16'(r_ch) < 16'(r_rows));
    assign o_status.last_ch = (r_ch == CH_BITS'(aob_pkg::CHANNELS - 1));

    // stage B: RAM data back
    logic                r_b_valid;
    logic [CH_BITS-1:0]  r_b_ch;
    logic [PW-1:0]       r_b_inc;
    logic                r_b_use;
    logic [PW-1:0]       w_phase_rd;
    logic [PW-1:0]       w_phase_cur;
    logic [aob_pkg::VOL_W-1:0] w_vol_rd;

    // stage C: quarter-wave index
    logic                r_c_valid;
    logic [QB-1:0]       r_c_sidx;
    logic                r_c_peak;
    logic                r_c_neg;
    logic [aob_pkg::VOL_W-1:0] r_c_vol;

    // stage D: sine value
    logic                r_d_valid;
    logic signed [aob_pkg::SIN_W-1:0] r_d_sin;
    logic [aob_pkg::VOL_W-1:0] r_d_vol;

    // stage E: product
    logic                r_e_valid;
    logic signed [aob_pkg::PROD_W-1:0] r_e_prod;

    logic signed [aob_pkg::ACC_W-1:0] r_acc;
    logic [aob_pkg::ACC_W-1:0]        r_mag;
    logic                             r_neg;
    logic [aob_pkg::ACC_W+aob_pkg::GAIN_W-1:0] r_scl;
    logic signed [aob_pkg::SMP_W-1:0] r_sample;

    aob_ram #(
        .WIDTH (aob_pkg::VOL_W),
        .DEPTH (aob_pkg::CHANNELS)
    ) u_vol_ram (
        .i_clk   (i_clk),
        .i_we    (w_pix_we),
        .i_waddr (w_pix_addr),
        .i_wdata (w_gray),
        .i_raddr (r_ch),
        .o_rdata (w_vol_rd)
    );

    assign w_phase_cur = r_phase_done ? w_phase_rd : '0;

    aob_ram #(
        .WIDTH (PW),
        .DEPTH (aob_pkg::CHANNELS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (r_b_valid),
        .i_waddr (r_b_ch),
        .i_wdata (w_phase_cur + r_b_inc),
        .i_raddr (r_ch),
        .o_rdata (w_phase_rd)
    );

    // sine table index from the phase before it advances
    logic [SE_BITS-1:0] w_idx;
    logic [1:0]         w_quad;
    logic [QB-1:0]      w_r;
    logic [QB:0]        w_mirror;

    assign w_idx    = w_phase_cur[PW-1 -: SE_BITS];
    assign w_quad   = w_idx[SE_BITS-1 -: 2];
    assign w_r      = w_idx[QB-1:0];
    assign w_mirror = (QB+1)'(aob_pkg::QUARTER) - {1'b0, w_r};

    logic [aob_pkg::SIN_W-2:0] w_sin_mag;
    assign w_sin_mag = r_c_peak ? aob_pkg::SINE_PEAK : aob_pkg::SINE_QTAB[r_c_sidx];

    logic signed [aob_pkg::SIN_W-1:0] w_sin_pos;
    assign w_sin_pos = $signed({1'b0, w_sin_mag});

    logic [aob_pkg::SCL_W-1:0] w_scaled;
    assign w_scaled = r_scl[aob_pkg::GAIN_SHIFT +: aob_pkg::SCL_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_valid  <= '0;
            r_phase_done <= 1'b0;
            r_ch         <= '0;
            r_b_valid    <= 1'b0;
            r_c_valid    <= 1'b0;
            r_d_valid    <= 1'b0;
            r_e_valid    <= 1'b0;
        end else begin
            if (w_pix_we) begin
                r_vol_valid[w_pix_addr] <= 1'b1;
            end
            if (i_cmd.phase_done) begin
                r_phase_done <= 1'b1;
            end
            if (i_cmd.start) begin
                r_ch <= '0;
            end else if (i_cmd.issue) begin
                r_ch <= o_status.last_ch ? '0 : r_ch + 1'b1;
            end
            r_b_valid <= i_cmd.issue;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_inc <= r_top_inc;
        end else if (i_cmd.issue) begin
            r_inc <= r_inc + r_inc_step;
        end

        r_b_ch  <= r_ch;
        r_b_inc <= r_inc;
        r_b_use <= w_active && r_vol_valid[r_ch];

        // odd quarters run backward; the mirror of offset zero is the peak
        r_c_sidx <= w_quad[0] ? w_mirror[QB-1:0] : w_r;
        r_c_peak <= w_quad[0] && (w_r == '0);
        r_c_neg  <= w_quad[1];
        r_c_vol  <= r_b_use ? w_vol_rd : '0;

        r_d_sin <= r_c_neg ? -w_sin_pos : w_sin_pos;
        r_d_vol <= r_c_vol;

        r_e_prod <= $signed({1'b0, r_d_vol}) * r_d_sin;

        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_e_valid) begin
            r_acc <= r_acc + aob_pkg::ACC_W'(r_e_prod);
        end

        if (i_cmd.mag) begin
            r_neg <= r_acc[aob_pkg::ACC_W-1];
            r_mag <= r_acc[aob_pkg::ACC_W-1] ? aob_pkg::ACC_W'(-r_acc)
                                             : aob_pkg::ACC_W'(r_acc);
        end
        if (i_cmd.mul) begin
            r_scl <= (aob_pkg::ACC_W+aob_pkg::GAIN_W)'(r_mag)
                   * (aob_pkg::ACC_W+aob_pkg::GAIN_W)'(r_gain);
        end
        if (i_cmd.load_out) begin
            if (r_neg) begin
                r_sample <= (w_scaled > aob_pkg::SCL_W'(32768)) ? 16'sh8000
                          : 16'(16'd0 - w_scaled[15:0]);
            end else begin
                r_sample <= (w_scaled > aob_pkg::SCL_W'(32767)) ? 16'sh7FFF
                          : $signed(w_scaled[15:0]);
            end
        end
    end

    assign o_audio_sample = r_sample;

endmodule
